>>> design/array_sum_mean_extremes_count_macros.svh
// ----------------------------------------------------------------------------
// array_sum_mean_extremes_count assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ARRAY_SUM_MEAN_EXTREMES_COUNT_MACROS_SVH
`define ARRAY_SUM_MEAN_EXTREMES_COUNT_MACROS_SVH

// checked only while out of reset
`define ASMEC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define ASMEC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/asmec_pkg.sv
// ----------------------------------------------------------------------------
// asmec_pkg
// widths, limits and the run record shared by the statistics block
// ----------------------------------------------------------------------------
package asmec_pkg;

    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 39;
    localparam int MEAN_W    = 40;
    localparam int COUNT_W   = 8;
    localparam int MAX_ITEMS = 128;

    // mean divider: numerator is |sum| * 512 + count, divisor 2 * count
    localparam int NUM_W      = SUM_W + 9;
    localparam int DEN_W      = COUNT_W + 1;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [SUM_W-1:0]   total_sum;
        logic signed [VALUE_W-1:0] largest;
        logic signed [VALUE_W-1:0] second_largest;
        logic signed [VALUE_W-1:0] smallest;
        logic signed [VALUE_W-1:0] second_smallest;
        logic [COUNT_W-1:0]        key_count;
        logic [COUNT_W-1:0]        value_count;
    } run_rec_t;

endpackage

>>> design/asmec_queue.sv
// ----------------------------------------------------------------------------
// asmec_queue
// short queue of finished run records between front and back
// ----------------------------------------------------------------------------
module asmec_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  asmec_pkg::run_rec_t push_rec,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output asmec_pkg::run_rec_t head_rec
);
    import asmec_pkg::*;

    run_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

>>> design/asmec_front.sv
// ----------------------------------------------------------------------------
// asmec_front
// takes values, tracks sum, count, top two, bottom two and key matches
// ----------------------------------------------------------------------------
module asmec_front (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic signed [asmec_pkg::VALUE_W-1:0]     cfg_wr_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [asmec_pkg::VALUE_W-1:0]     s_sample_value,
    input  logic                                     s_last_value,
    input  logic                                     q_full,
    output logic                                     push,
    output asmec_pkg::run_rec_t                      push_rec
);
    import asmec_pkg::*;

    logic signed [VALUE_W-1:0] search_key_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COUNT_W-1:0]        key_reg, key_next;
    logic signed [VALUE_W-1:0] top_reg, top_next;
    logic signed [VALUE_W-1:0] ntop_reg, ntop_next;
    logic signed [VALUE_W-1:0] bot_reg, bot_next;
    logic signed [VALUE_W-1:0] nbot_reg, nbot_next;
    logic                      accept, run_end;
    logic signed [VALUE_W-1:0] v;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign v       = s_sample_value;

    // running values including the current sample
    always_comb begin
        top_next  = top_reg;
        ntop_next = ntop_reg;
        bot_next  = bot_reg;
        nbot_next = nbot_reg;
        if (count_reg == '0) begin
            top_next  = v;
            ntop_next = v;
            bot_next  = v;
            nbot_next = v;
        end else if (count_reg == COUNT_W'(1)) begin
            if (v >= top_reg) begin
                ntop_next = top_reg;
                top_next  = v;
            end else begin
                ntop_next = v;
            end
            if (v <= bot_reg) begin
                nbot_next = bot_reg;
                bot_next  = v;
            end else begin
                nbot_next = v;
            end
        end else begin
            if (v >= top_reg) begin
                ntop_next = top_reg;
                top_next  = v;
            end else if (v > ntop_reg) begin
                ntop_next = v;
            end
            if (v <= bot_reg) begin
                nbot_next = bot_reg;
                bot_next  = v;
            end else if (v < nbot_reg) begin
                nbot_next = v;
            end
        end
        sum_next   = sum_reg + SUM_W'(v);
        count_next = count_reg + 1'b1;
        key_next   = (v == search_key_reg) ? key_reg + 1'b1 : key_reg;
    end

    // overlong runs close on their last allowed value
    assign run_end = s_last_value || (count_next == COUNT_W'(MAX_ITEMS));
    assign push    = accept && run_end;

    always_comb begin
        push_rec.total_sum       = sum_next;
        push_rec.largest         = top_next;
        push_rec.second_largest  = ntop_next;
        push_rec.smallest        = bot_next;
        push_rec.second_smallest = nbot_next;
        push_rec.key_count       = key_next;
        push_rec.value_count     = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_key_reg <= '0;
        end else if (cfg_wr_en) begin
            search_key_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            key_reg   <= '0;
            top_reg   <= '0;
            ntop_reg  <= '0;
            bot_reg   <= '0;
            nbot_reg  <= '0;
        end else if (accept) begin
            if (run_end) begin
                sum_reg   <= '0;
                count_reg <= '0;
                key_reg   <= '0;
                top_reg   <= '0;
                ntop_reg  <= '0;
                bot_reg   <= '0;
                nbot_reg  <= '0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                key_reg   <= key_next;
                top_reg   <= top_next;
                ntop_reg  <= ntop_next;
                bot_reg   <= bot_next;
                nbot_reg  <= nbot_next;
            end
        end
    end

endmodule

>>> design/asmec_back.sv
// ----------------------------------------------------------------------------
// asmec_back
// bit-serial mean division and the result output register
// ----------------------------------------------------------------------------
module asmec_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  asmec_pkg::run_rec_t                   q_head,
    output logic                                  pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [asmec_pkg::SUM_W-1:0]    m_total_sum,
    output logic signed [asmec_pkg::MEAN_W-1:0]   m_mean_fixed,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_largest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_second_largest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_smallest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_second_smallest,
    output logic [asmec_pkg::COUNT_W-1:0]         m_key_count,
    output logic [asmec_pkg::COUNT_W-1:0]         m_value_count,
    output logic                                  m_too_few
);
    import asmec_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

    back_state_t           state_reg, state_next;
    run_rec_t              rec_reg, rec_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]  step_reg, step_next;
    logic                  valid_reg, valid_next;
    run_rec_t              out_reg, out_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;

    logic [SUM_W-1:0]      mag;
    logic [DEN_W:0]        trial, diff;
    logic                  ge;
    logic [MEAN_W-1:0]     quot;
    logic                  load_out;

    assign mag   = q_head.total_sum[SUM_W-1] ? SUM_W'(0) - q_head.total_sum
                                             : q_head.total_sum;
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign quot  = num_reg[MEAN_W-1:0];

    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_DONE) && (!valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        rec_next   = rec_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        mean_next  = mean_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    rec_next   = q_head;
                    num_next   = {mag, 9'b0} + NUM_W'(q_head.value_count);
                    rem_next   = '0;
                    den_next   = {q_head.value_count, 1'b0};
                    neg_next   = q_head.total_sum[SUM_W-1];
                    step_next  = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                // one quotient bit per cycle, restoring
                rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (load_out) begin
                    out_next   = rec_reg;
                    mean_next  = neg_reg ? MEAN_W'(0) - quot : quot;
                    valid_next = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        rec_reg  <= rec_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        out_reg  <= out_next;
        mean_reg <= mean_next;
    end

    assign m_valid           = valid_reg;
    assign m_total_sum       = out_reg.total_sum;
    assign m_mean_fixed      = mean_reg;
    assign m_largest         = out_reg.largest;
    assign m_second_largest  = out_reg.second_largest;
    assign m_smallest        = out_reg.smallest;
    assign m_second_smallest = out_reg.second_smallest;
    assign m_key_count       = out_reg.key_count;
    assign m_value_count     = out_reg.value_count;
    assign m_too_few         = (out_reg.value_count < COUNT_W'(2));

endmodule

>>> design/array_sum_mean_extremes_count.sv
// a run's record passes the queue, the serial mean divider and the output register in turn
// throughput: one value per cycle unless the queue is full; the divider takes one run at a time
// two finished runs can wait in the queue; input stalls only when it is full
// reset: synchronous active-low aresetn clears run state, queue, divider and search key (to 0)
// ----------------------------------------------------------------------------
// array_sum_mean_extremes_count
// run statistics: sum, rounded fixed-point mean, top two, bottom two, key count
// ----------------------------------------------------------------------------
module array_sum_mean_extremes_count (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // search key register
    input  logic                                  cfg_wr_en,
    input  logic signed [asmec_pkg::VALUE_W-1:0]  cfg_wr_data,
    // value stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [asmec_pkg::VALUE_W-1:0]  s_sample_value,
    input  logic                                  s_last_value,
    // result stream
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [asmec_pkg::SUM_W-1:0]    m_total_sum,
    output logic signed [asmec_pkg::MEAN_W-1:0]   m_mean_fixed,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_largest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_second_largest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_smallest,
    output logic signed [asmec_pkg::VALUE_W-1:0]  m_second_smallest,
    output logic [asmec_pkg::COUNT_W-1:0]         m_key_count,
    output logic [asmec_pkg::COUNT_W-1:0]         m_value_count,
    output logic                                  m_too_few
);
    import asmec_pkg::*;

    // finished run records flowing front to back
    logic     push, pop, q_full, q_empty;
    run_rec_t push_rec, head_rec;

    // front: accumulates per transfer, pushes a record when the run closes
    asmec_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_last_value   (s_last_value),
        .q_full         (q_full),
        .push           (push),
        .push_rec       (push_rec)
    );

    // decoupling queue so the divider never blocks value intake directly
    asmec_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_rec (head_rec)
    );

    // back: mean division and output register
    asmec_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_empty           (q_empty),
        .q_head            (head_rec),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_total_sum       (m_total_sum),
        .m_mean_fixed      (m_mean_fixed),
        .m_largest         (m_largest),
        .m_second_largest  (m_second_largest),
        .m_smallest        (m_smallest),
        .m_second_smallest (m_second_smallest),
        .m_key_count       (m_key_count),
        .m_value_count     (m_value_count),
        .m_too_few         (m_too_few)
    );

endmodule

>>> design/asmec_checker.sv
// ----------------------------------------------------------------------------
// asmec_checker
// port-level checks on the result stream of the statistics block
// ----------------------------------------------------------------------------
`include "array_sum_mean_extremes_count_macros.svh"

module asmec_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [asmec_pkg::SUM_W-1:0]    m_total_sum,
    input logic signed [asmec_pkg::MEAN_W-1:0]   m_mean_fixed,
    input logic signed [asmec_pkg::VALUE_W-1:0]  m_largest,
    input logic signed [asmec_pkg::VALUE_W-1:0]  m_second_largest,
    input logic signed [asmec_pkg::VALUE_W-1:0]  m_smallest,
    input logic signed [asmec_pkg::VALUE_W-1:0]  m_second_smallest,
    input logic [asmec_pkg::COUNT_W-1:0]         m_key_count,
    input logic [asmec_pkg::COUNT_W-1:0]         m_value_count,
    input logic                                  m_too_few
);
    logic order_ok;
    logic counts_ok;

    assign order_ok  = (m_largest >= m_second_largest) && (m_second_largest >= m_smallest)
                       && (m_smallest <= m_second_smallest);
    assign counts_ok = (m_key_count <= m_value_count) && (m_too_few == (m_value_count < 8'd2));

    // stalled result holds
    `ASMEC_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_total_sum) && $stable(m_mean_fixed), "result dropped")
    // extremes ordered
    `ASMEC_ASSERT(a_order, m_valid |-> order_ok, "extremes out of order")
    // counts consistent
    `ASMEC_ASSERT(a_counts, m_valid |-> counts_ok, "count fields inconsistent")
    // no result right after reset
    `ASMEC_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind array_sum_mean_extremes_count asmec_checker u_asmec_checker (.*);
